/* rtl/tpp_pkg.sv */
`default_nettype none
package tpp_pkg;

	localparam int COORD_W    = 32;
	localparam int VEC_W      = COORD_W + 1;   // edge / offset components
	localparam int HALF_W     = VEC_W;         // split point of wide magnitudes
	localparam int PROD_W     = 2 * VEC_W;     // one coordinate product
	localparam int DOT_W      = PROD_W + 2;    // sum of three products
	localparam int MAG_W      = 2 * HALF_W;    // dot magnitude, always below 2^66
	localparam int GRAM_W     = 2 * MAG_W;     // product of two dot magnitudes
	localparam int WIDE_W     = GRAM_W + 2;    // determinant and numerators, signed
	localparam int DIV_W      = WIDE_W + 2;    // partial remainder
	localparam int Q_W        = 17;            // quotient bits, Q1.16 up to one
	localparam int FRAC_W     = Q_W - 1;
	localparam int RPROD_W    = 51;            // coordinate times edge component
	localparam int RES_W      = RPROD_W + 1;   // residual per axis, signed
	localparam int RMAG_W     = RES_W - 1;
	localparam int RLO_W      = 26;
	localparam int RHI_W      = RMAG_W - RLO_W;
	localparam int SQ_W       = 2 * RMAG_W;
	localparam int DIST_W     = SQ_W + 2;
	localparam int TOL_W      = 31;
	localparam int LIMIT_W    = 63;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = LIMIT_W;
	localparam int THR_SHIFT  = 32;

	localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(66);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOLERANCE = 2'd0,
		REG_LIMIT     = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_HIT   = 2'd0,
		ST_FAR   = 2'd1,
		ST_DEGEN = 2'd2
	} status_t;

	typedef logic [VEC_W-1:0] vec_t;

	typedef struct packed {
		vec_t [2:0] s;
		vec_t [2:0] t;
		vec_t [2:0] d;
		logic       deg;
	} geo_t;

	typedef struct packed {
		logic [PROD_W-1:0] ll;
		logic [PROD_W-1:0] lh;
		logic [PROD_W-1:0] hl;
		logic [PROD_W-1:0] hh;
		logic              neg;
	} pp_t;

	typedef struct packed {
		logic [Q_W-1:0] u0;
		logic [Q_W-1:0] u1;
		logic           deg;
	} tail_t;

	function automatic logic [PROD_W-1:0] smul_vec(input vec_t a, input vec_t b);
		logic signed [PROD_W-1:0] p;
		p = $signed(a) * $signed(b);
		return p;
	endfunction

	function automatic logic [DOT_W-1:0] dot_sum(input logic [2:0][PROD_W-1:0] p);
		logic signed [DOT_W-1:0] acc;
		acc = $signed(p[0]) + $signed(p[1]) + $signed(p[2]);
		return acc;
	endfunction

	function automatic logic [MAG_W-1:0] dot_mag(input logic [DOT_W-1:0] x);
		logic [DOT_W-1:0] a;
		a = x[DOT_W-1] ? -x : x;
		return a[MAG_W-1:0];
	endfunction

	function automatic logic [GRAM_W-1:0] pp_join(input pp_t p);
		logic [GRAM_W-1:0] r;
		r = (GRAM_W'(p.hh) << (2 * HALF_W)) + (GRAM_W'(p.lh) << HALF_W)
			+ (GRAM_W'(p.hl) << HALF_W) + GRAM_W'(p.ll);
		return r;
	endfunction

	function automatic logic [WIDE_W-1:0] with_sign(input logic [GRAM_W-1:0] m, input logic neg);
		logic [WIDE_W-1:0] e;
		e = WIDE_W'(m);
		return neg ? -e : e;
	endfunction

	function automatic logic [RPROD_W-1:0] coord_mul(input logic [Q_W-1:0] u, input vec_t v);
		logic signed [RPROD_W-1:0] p;
		p = $signed({1'b0, u}) * $signed(v);
		return p;
	endfunction

endpackage
`default_nettype wire

/* rtl/tpp_in_if.sv */
`default_nettype none
interface tpp_in_if;
	logic valid;
	logic ready;
	logic signed [tpp_pkg::COORD_W-1:0] a_x;
	logic signed [tpp_pkg::COORD_W-1:0] a_y;
	logic signed [tpp_pkg::COORD_W-1:0] a_z;
	logic signed [tpp_pkg::COORD_W-1:0] b_x;
	logic signed [tpp_pkg::COORD_W-1:0] b_y;
	logic signed [tpp_pkg::COORD_W-1:0] b_z;
	logic signed [tpp_pkg::COORD_W-1:0] corner_x;
	logic signed [tpp_pkg::COORD_W-1:0] corner_y;
	logic signed [tpp_pkg::COORD_W-1:0] corner_z;
	logic signed [tpp_pkg::COORD_W-1:0] query_x;
	logic signed [tpp_pkg::COORD_W-1:0] query_y;
	logic signed [tpp_pkg::COORD_W-1:0] query_z;

	modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, corner_x, corner_y, corner_z,
		query_x, query_y, query_z, input ready);
	modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, corner_x, corner_y, corner_z,
		query_x, query_y, query_z, output ready);
endinterface
`default_nettype wire

/* rtl/tpp_out_if.sv */
`default_nettype none
interface tpp_out_if;
	logic valid;
	logic ready;
	tpp_pkg::status_t status;
	logic [tpp_pkg::Q_W-1:0] local_first;
	logic [tpp_pkg::Q_W-1:0] local_second;

	modport source (output valid, status, local_first, local_second, input ready);
	modport sink (input valid, status, local_first, local_second, output ready);
endinterface
`default_nettype wire

/* rtl/tpp_cfg_if.sv */
`default_nettype none
interface tpp_cfg_if;
	logic valid;
	logic ready;
	logic [tpp_pkg::CFG_IDX_W-1:0]  index;
	logic [tpp_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/triangle_point_projection_unit.sv */
`default_nettype none
// Each accepted item passes every stage in order before its result reaches the output register.
// Throughput: one item per cycle; 10 setup stages, 17 quotient stages (one bit each,
// both coordinates in parallel) and 6 residual stages, all advancing together.
// A held output stalls the whole pipe; bubbles drain only while output is free.
// Reset clears the stage valid bits and loads tolerance 66 and limit 0.
module triangle_point_projection_unit (
	input  logic      clk,
	input  logic      arst_n,
	tpp_in_if.sink    item,
	tpp_cfg_if.sink   cfg,
	tpp_out_if.source result
);
	import tpp_pkg::*;

	localparam int NST  = 10 + Q_W + 6;
	localparam int D_SS = 0;
	localparam int D_ST = 1;
	localparam int D_TT = 2;
	localparam int D_SD = 3;
	localparam int D_TD = 4;
	// operand pairs: ss*tt, st*st, tt*sd, st*td, ss*td, st*sd
	localparam int PA [6] = '{D_SS, D_ST, D_TT, D_ST, D_SS, D_ST};
	localparam int PB [6] = '{D_TT, D_ST, D_SD, D_TD, D_TD, D_SD};

	logic               en;
	logic [NST-1:0]     vld_q;
	logic [TOL_W-1:0]   tol_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [2*TOL_W-1:0] tolsq_q;

	geo_t                    geo_s1, geo_s2, geo_s3, geo_s4, geo_s5;
	geo_t                    geo_s6, geo_s7, geo_s8, geo_s9, geo_s10;
	logic [2:0][PROD_W-1:0]  ss_s2, st_s2, tt_s2, sd_s2, td_s2;
	logic [4:0][DOT_W-1:0]   dot_s3;
	logic [4:0][MAG_W-1:0]   mag_s4;
	logic [4:0]              neg_s4;
	pp_t  [5:0]              pp_s5;
	logic [5:0][GRAM_W-1:0]  gm_s6;
	logic [5:0]              gneg_s6;
	logic [5:0][WIDE_W-1:0]  gs_s7;
	logic [WIDE_W-1:0]       det_s8, n0_s8, n1_s8;
	logic [WIDE_W-1:0]       n0c, n1c;
	logic [WIDE_W-1:0]       det_s9, n0_s9, n1_s9, sum_s9;
	logic [WIDE_W-1:0]       den_s10, n0_s10, n1_s10;

	logic [DIV_W-1:0] rem0_dv [Q_W];
	logic [DIV_W-1:0] rem1_dv [Q_W];
	logic [DIV_W-1:0] den_dv  [Q_W];
	logic [Q_W-1:0]   q0_dv   [Q_W];
	logic [Q_W-1:0]   q1_dv   [Q_W];
	geo_t             geo_dv  [Q_W];

	logic [2:0][RPROD_W-1:0] pu_r1, pv_r1, dq_r1;
	logic [2:0][RES_W-1:0]   res_r2;
	logic [2:0][RMAG_W-1:0]  rmag_r3;
	logic [2:0][2*RLO_W-1:0] ll_r4;
	logic [2:0][SQ_W/2:0]    lh_r4;
	logic [2:0][2*RHI_W-1:0] hh_r4;
	logic [2:0][SQ_W-1:0]    sq_r5;
	tail_t                   tl_r1, tl_r2, tl_r3, tl_r4, tl_r5;
	logic [DIST_W-1:0]       dist_sum;
	logic                    hit;
	status_t                 status_r6;
	logic [Q_W-1:0]          lf_r6, ls_r6;

	// whole pipe advances unless a finished result is held
	assign en          = !vld_q[NST-1] || result.ready;
	assign item.ready  = en;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			tol_q   <= TOL_RESET;
			limit_q <= LIMIT_RESET;
		end else begin
			if (en)
				vld_q <= {vld_q[NST-2:0], item.valid};
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_TOLERANCE: tol_q   <= cfg.data[TOL_W-1:0];
					REG_LIMIT:     limit_q <= cfg.data[LIMIT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk)
		tolsq_q <= tol_q * tol_q;

	always_comb begin
		n0c = n0_s8[WIDE_W-1] ? '0 : n0_s8;
		n1c = n1_s8[WIDE_W-1] ? '0 : n1_s8;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: edges and offset from vertex 0
			geo_s1.s[0] <= {item.b_x[COORD_W-1], item.b_x} - {item.a_x[COORD_W-1], item.a_x};
			geo_s1.s[1] <= {item.b_y[COORD_W-1], item.b_y} - {item.a_y[COORD_W-1], item.a_y};
			geo_s1.s[2] <= {item.b_z[COORD_W-1], item.b_z} - {item.a_z[COORD_W-1], item.a_z};
			geo_s1.t[0] <= {item.corner_x[COORD_W-1], item.corner_x}
				- {item.a_x[COORD_W-1], item.a_x};
			geo_s1.t[1] <= {item.corner_y[COORD_W-1], item.corner_y}
				- {item.a_y[COORD_W-1], item.a_y};
			geo_s1.t[2] <= {item.corner_z[COORD_W-1], item.corner_z}
				- {item.a_z[COORD_W-1], item.a_z};
			geo_s1.d[0] <= {item.query_x[COORD_W-1], item.query_x}
				- {item.a_x[COORD_W-1], item.a_x};
			geo_s1.d[1] <= {item.query_y[COORD_W-1], item.query_y}
				- {item.a_y[COORD_W-1], item.a_y};
			geo_s1.d[2] <= {item.query_z[COORD_W-1], item.query_z}
				- {item.a_z[COORD_W-1], item.a_z};
			geo_s1.deg  <= 1'b0;

			// s2: coordinate products
			for (int i = 0; i < 3; i++) begin
				ss_s2[i] <= smul_vec(geo_s1.s[i], geo_s1.s[i]);
				st_s2[i] <= smul_vec(geo_s1.s[i], geo_s1.t[i]);
				tt_s2[i] <= smul_vec(geo_s1.t[i], geo_s1.t[i]);
				sd_s2[i] <= smul_vec(geo_s1.s[i], geo_s1.d[i]);
				td_s2[i] <= smul_vec(geo_s1.t[i], geo_s1.d[i]);
			end
			geo_s2 <= geo_s1;

			// s3: dot products
			dot_s3[D_SS] <= dot_sum(ss_s2);
			dot_s3[D_ST] <= dot_sum(st_s2);
			dot_s3[D_TT] <= dot_sum(tt_s2);
			dot_s3[D_SD] <= dot_sum(sd_s2);
			dot_s3[D_TD] <= dot_sum(td_s2);
			geo_s3 <= geo_s2;

			// s4: sign and magnitude
			for (int k = 0; k < 5; k++) begin
				mag_s4[k] <= dot_mag(dot_s3[k]);
				neg_s4[k] <= dot_s3[k][DOT_W-1];
			end
			geo_s4 <= geo_s3;

			// s5: half-word partial products of the six Gram terms
			for (int j = 0; j < 6; j++) begin
				pp_s5[j].ll  <= mag_s4[PA[j]][HALF_W-1:0] * mag_s4[PB[j]][HALF_W-1:0];
				pp_s5[j].lh  <= mag_s4[PA[j]][HALF_W-1:0] * mag_s4[PB[j]][MAG_W-1:HALF_W];
				pp_s5[j].hl  <= mag_s4[PA[j]][MAG_W-1:HALF_W] * mag_s4[PB[j]][HALF_W-1:0];
				pp_s5[j].hh  <= mag_s4[PA[j]][MAG_W-1:HALF_W] * mag_s4[PB[j]][MAG_W-1:HALF_W];
				pp_s5[j].neg <= neg_s4[PA[j]] ^ neg_s4[PB[j]];
			end
			geo_s5 <= geo_s4;

			// s6, s7: assemble and sign
			for (int j = 0; j < 6; j++) begin
				gm_s6[j]   <= pp_join(pp_s5[j]);
				gneg_s6[j] <= pp_s5[j].neg;
				gs_s7[j]   <= with_sign(gm_s6[j], gneg_s6[j]);
			end
			geo_s6 <= geo_s5;
			geo_s7 <= geo_s6;

			// s8: determinant and Cramer numerators
			det_s8 <= gs_s7[0] - gs_s7[1];
			n0_s8  <= gs_s7[2] - gs_s7[3];
			n1_s8  <= gs_s7[4] - gs_s7[5];
			geo_s8 <= geo_s7;

			// s9: degenerate test, clamp at zero
			geo_s9.s   <= geo_s8.s;
			geo_s9.t   <= geo_s8.t;
			geo_s9.d   <= geo_s8.d;
			geo_s9.deg <= ($signed(det_s8) <= $signed(WIDE_W'(limit_q)));
			det_s9     <= det_s8;
			n0_s9      <= n0c;
			n1_s9      <= n1c;
			sum_s9     <= n0c + n1c;

			// s10: rescale divisor when the sum exceeds one
			den_s10 <= (sum_s9 > det_s9) ? sum_s9 : det_s9;
			n0_s10  <= n0_s9;
			n1_s10  <= n1_s9;
			geo_s10 <= geo_s9;
		end
	end

	// restoring division, one quotient bit per stage, MSB first
	for (genvar k = 0; k < Q_W; k++) begin : g_div
		logic [DIV_W-1:0] r0, r1, dn, d0, d1;
		logic [Q_W-1:0]   qa, qb;
		geo_t             gi;
		logic             ge0, ge1;

		if (k == 0) begin : g_first
			assign r0 = DIV_W'(n0_s10);
			assign r1 = DIV_W'(n1_s10);
			assign dn = DIV_W'(den_s10);
			assign qa = '0;
			assign qb = '0;
			assign gi = geo_s10;
		end else begin : g_step
			assign r0 = {rem0_dv[k-1][DIV_W-2:0], 1'b0};
			assign r1 = {rem1_dv[k-1][DIV_W-2:0], 1'b0};
			assign dn = den_dv[k-1];
			assign qa = q0_dv[k-1];
			assign qb = q1_dv[k-1];
			assign gi = geo_dv[k-1];
		end

		assign ge0 = r0 >= dn;
		assign ge1 = r1 >= dn;
		assign d0  = r0 - dn;
		assign d1  = r1 - dn;

		always_ff @(posedge clk) begin
			if (en) begin
				rem0_dv[k] <= ge0 ? d0 : r0;
				rem1_dv[k] <= ge1 ? d1 : r1;
				q0_dv[k]   <= {qa[Q_W-2:0], ge0};
				q1_dv[k]   <= {qb[Q_W-2:0], ge1};
				den_dv[k]  <= dn;
				geo_dv[k]  <= gi;
			end
		end
	end

	always_comb begin
		dist_sum = DIST_W'(sq_r5[0]) + DIST_W'(sq_r5[1]) + DIST_W'(sq_r5[2]);
		hit      = dist_sum < (DIST_W'(tolsq_q) << THR_SHIFT);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// r1: projected offset terms
			for (int i = 0; i < 3; i++) begin
				pu_r1[i] <= coord_mul(q0_dv[Q_W-1], geo_dv[Q_W-1].s[i]);
				pv_r1[i] <= coord_mul(q1_dv[Q_W-1], geo_dv[Q_W-1].t[i]);
				dq_r1[i] <= {{(RPROD_W-VEC_W-FRAC_W){geo_dv[Q_W-1].d[i][VEC_W-1]}},
					geo_dv[Q_W-1].d[i], {FRAC_W{1'b0}}};
			end
			tl_r1.u0  <= q0_dv[Q_W-1];
			tl_r1.u1  <= q1_dv[Q_W-1];
			tl_r1.deg <= geo_dv[Q_W-1].deg;

			// r2..r5: residual, magnitude, split square
			for (int i = 0; i < 3; i++) begin
				res_r2[i]  <= $signed(dq_r1[i]) - $signed(pu_r1[i]) - $signed(pv_r1[i]);
				rmag_r3[i] <= res_r2[i][RES_W-1] ? RMAG_W'(-res_r2[i]) : res_r2[i][RMAG_W-1:0];
				ll_r4[i]   <= rmag_r3[i][RLO_W-1:0] * rmag_r3[i][RLO_W-1:0];
				lh_r4[i]   <= rmag_r3[i][RLO_W-1:0] * rmag_r3[i][RMAG_W-1:RLO_W];
				hh_r4[i]   <= rmag_r3[i][RMAG_W-1:RLO_W] * rmag_r3[i][RMAG_W-1:RLO_W];
				sq_r5[i]   <= (SQ_W'(hh_r4[i]) << (2 * RLO_W)) + (SQ_W'(lh_r4[i]) << (RLO_W + 1))
					+ SQ_W'(ll_r4[i]);
			end
			tl_r2 <= tl_r1;
			tl_r3 <= tl_r2;
			tl_r4 <= tl_r3;
			tl_r5 <= tl_r4;

			// r6: distance test, output register
			if (tl_r5.deg) begin
				status_r6 <= ST_DEGEN;
				lf_r6     <= '0;
				ls_r6     <= '0;
			end else if (hit) begin
				status_r6 <= ST_HIT;
				lf_r6     <= tl_r5.u0;
				ls_r6     <= tl_r5.u1;
			end else begin
				status_r6 <= ST_FAR;
				lf_r6     <= '0;
				ls_r6     <= '0;
			end
		end
	end

	assign result.valid        = vld_q[NST-1];
	assign result.status       = status_r6;
	assign result.local_first  = lf_r6;
	assign result.local_second = ls_r6;

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status != ST_HIT |-> result.local_first == '0
			&& result.local_second == '0)
		else $error("coordinates nonzero on a miss");

	a_sum_le_one: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status == ST_HIT |->
			({1'b0, result.local_first} + {1'b0, result.local_second}) <= (Q_W + 1)'(1 << FRAC_W))
		else $error("coordinates sum above one");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved during stall");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> vld_q[0])
		else $error("accepted item lost at entry");

endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
	import tpp_pkg::*;

	localparam int ONE = 65536;
	localparam int CMAX = 32'h7fff_ffff;
	localparam int CMIN = 32'h8000_0000;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 2'd3;
	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT = 4000;

	typedef logic signed [255:0] big_t;
	typedef struct {
		int a[3];
		int b[3];
		int k[3];
		int q[3];
	} tri_query_t;
	typedef struct {
		status_t        st;
		logic [Q_W-1:0] first;
		logic [Q_W-1:0] second;
	} proj_t;
	typedef struct {
		tri_query_t tq;
		bit         known;
		proj_t      want;
	} vector_t;

	logic clk;
	logic arst_n;

	tpp_in_if  item_ch ();
	tpp_cfg_if cfg_ch ();
	tpp_out_if res_ch ();

	triangle_point_projection_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.cfg    (cfg_ch),
		.result (res_ch)
	);

	logic [TOL_W-1:0]   tol_reg;
	logic [LIMIT_W-1:0] limit_reg;
	proj_t              pending_proj[$];
	vector_t            vectors[$];
	int                 err_count = 0;
	int                 idle_cycles = 0;
	bit                 steady;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	task automatic report(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		err_count++;
	endtask

	function automatic proj_t project(input tri_query_t tq);
		longint s[3], t[3], d[3];
		big_t ss, st, tt, dv0, dv1, det, n0, n1, tot, den, sq_dist, thr, lim;
		longint r, tsq;
		logic [Q_W-1:0] u0, u1;
		proj_t p;
		ss = 0; st = 0; tt = 0; dv0 = 0; dv1 = 0; sq_dist = 0;
		for (int i = 0; i < 3; i++) begin
			s[i] = longint'(tq.b[i]) - longint'(tq.a[i]);
			t[i] = longint'(tq.k[i]) - longint'(tq.a[i]);
			d[i] = longint'(tq.q[i]) - longint'(tq.a[i]);
			ss += big_t'(s[i]) * big_t'(s[i]);
			st += big_t'(s[i]) * big_t'(t[i]);
			tt += big_t'(t[i]) * big_t'(t[i]);
			dv0 += big_t'(s[i]) * big_t'(d[i]);
			dv1 += big_t'(t[i]) * big_t'(d[i]);
		end
		det = ss * tt - st * st;
		lim = '0;
		lim[LIMIT_W-1:0] = limit_reg;
		p.st = ST_DEGEN; p.first = '0; p.second = '0;
		if (det > lim) begin
			n0 = tt * dv0 - st * dv1;
			n1 = ss * dv1 - st * dv0;
			if (n0 < 0) n0 = 0;
			if (n1 < 0) n1 = 0;
			tot = n0 + n1;
			den = (tot > det) ? tot : det;
			u0 = Q_W'((n0 <<< 16) / den);
			u1 = Q_W'((n1 <<< 16) / den);
			for (int i = 0; i < 3; i++) begin
				r = d[i] * ONE - longint'(u0) * s[i] - longint'(u1) * t[i];
				sq_dist += big_t'(r) * big_t'(r);
			end
			tsq = longint'(tol_reg) * longint'(tol_reg);
			thr = big_t'(tsq) <<< THR_SHIFT;
			if (sq_dist < thr) begin
				p.st = ST_HIT; p.first = u0; p.second = u1;
			end else begin
				p.st = ST_FAR;
			end
		end
		return p;
	endfunction

	function automatic tri_query_t make_tq(input int ax, ay, az, bx, by, bz,
			kx, ky, kz, qx, qy, qz);
		tri_query_t tq;
		tq.a = '{ax, ay, az}; tq.b = '{bx, by, bz};
		tq.k = '{kx, ky, kz}; tq.q = '{qx, qy, qz};
		return tq;
	endfunction

	task automatic add_vector(input tri_query_t tq, input bit known,
			input status_t st, input int f, input int sc);
		vector_t v;
		v.tq = tq; v.known = known;
		v.want.st = st; v.want.first = Q_W'(f); v.want.second = Q_W'(sc);
		vectors.push_back(v);
	endtask

	// mostly well-formed triangles with queries near their plane, plus noise
	function automatic tri_query_t random_tq();
		tri_query_t tq;
		int kind, w0, w1, span;
		kind = $urandom_range(0, 99);
		if (kind < 20) begin
			for (int i = 0; i < 3; i++) begin
				tq.a[i] = $urandom; tq.b[i] = $urandom;
				tq.k[i] = $urandom; tq.q[i] = $urandom;
			end
		end else begin
			span = (kind < 35) ? (1 << 16) : (1 << $urandom_range(8, 20));
			w0 = $urandom_range(0, 320);
			w1 = $urandom_range(0, 320);
			for (int i = 0; i < 3; i++) begin
				tq.a[i] = $signed($urandom_range(0, 32'h7fff_0000)) - 32'h3fff_8000;
				tq.b[i] = tq.a[i] + $signed($urandom_range(0, 2 * span)) - span;
				if (kind < 45)
					tq.k[i] = tq.a[i] + 2 * (tq.b[i] - tq.a[i]);
				else
					tq.k[i] = tq.a[i] + $signed($urandom_range(0, 2 * span)) - span;
				tq.q[i] = tq.a[i] + ((w0 * (tq.b[i] - tq.a[i])
					+ w1 * (tq.k[i] - tq.a[i])) >>> 8);
				if ($urandom_range(0, 2) == 0)
					tq.q[i] += $signed($urandom_range(0, 160)) - 80;
			end
		end
		return tq;
	endfunction

	task automatic send(input tri_query_t tq, input bit known, input proj_t want);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.a_x <= tq.a[0]; item_ch.a_y <= tq.a[1]; item_ch.a_z <= tq.a[2];
		item_ch.b_x <= tq.b[0]; item_ch.b_y <= tq.b[1]; item_ch.b_z <= tq.b[2];
		item_ch.corner_x <= tq.k[0]; item_ch.corner_y <= tq.k[1];
		item_ch.corner_z <= tq.k[2];
		item_ch.query_x <= tq.q[0]; item_ch.query_y <= tq.q[1];
		item_ch.query_z <= tq.q[2];
		do @(posedge clk); while (!item_ch.ready);
		pending_proj.push_back(known ? want : project(tq));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		// hold off until the pipe has drained
		item_ch.valid <= 1'b0;
		while (pending_proj.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_TOLERANCE) tol_reg = val[TOL_W-1:0];
		else if (idx == REG_LIMIT) limit_reg = val[LIMIT_W-1:0];
	endtask

	task automatic run_random(input int count);
		proj_t none;
		none = '{ST_HIT, '0, '0};
		for (int n = 0; n < count; n++) send(random_tq(), 1'b0, none);
	endtask

	// result side: random backpressure, checked against queued projections
	int stall_left = 0;
	always @(posedge clk) begin
		proj_t exp_p;
		logic  nxt_ready;
		if (res_ch.valid && res_ch.ready) begin
			if (pending_proj.size() == 0) begin
				report($sformatf("unexpected result status=%0d", res_ch.status));
			end else begin
				exp_p = pending_proj.pop_front();
				if (res_ch.status != exp_p.st)
					report($sformatf("status %0d, want %0d", res_ch.status, exp_p.st));
				if (res_ch.local_first != exp_p.first)
					report($sformatf("local_first %0d, want %0d",
						res_ch.local_first, exp_p.first));
				if (res_ch.local_second != exp_p.second)
					report($sformatf("local_second %0d, want %0d",
						res_ch.local_second, exp_p.second));
			end
			stall_left = steady ? 0 : $urandom_range(0, 4);
		end
		if (stall_left > 0) begin
			stall_left--;
			nxt_ready = 1'b0;
		end else begin
			nxt_ready = arst_n;
		end
		res_ch.ready <= nxt_ready;
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		proj_t none;
		none = '{ST_HIT, '0, '0};
		steady = 1'b0;
		tol_reg = TOL_RESET; limit_reg = LIMIT_RESET;
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.a_x <= 0; item_ch.a_y <= 0; item_ch.a_z <= 0;
		item_ch.b_x <= 0; item_ch.b_y <= 0; item_ch.b_z <= 0;
		item_ch.corner_x <= 0; item_ch.corner_y <= 0; item_ch.corner_z <= 0;
		item_ch.query_x <= 0; item_ch.query_y <= 0; item_ch.query_z <= 0;
		cfg_ch.valid <= 1'b0; cfg_ch.index <= REG_TOLERANCE; cfg_ch.data <= '0;

		add_vector(make_tq(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_DEGEN, 0, 0);
		add_vector(make_tq(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, 0), 1, ST_HIT, 0, 0);
		add_vector(make_tq(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, 0, 0), 1, ST_HIT, ONE, 0);
		add_vector(make_tq(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, ONE, 0), 1, ST_HIT, 0, ONE);
		add_vector(make_tq(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1, ST_FAR, 0, 0);
		// collinear vertices
		add_vector(make_tq(0, 0, 0, ONE, 0, 0, 2 * ONE, 0, 0, 5, 7, 9), 1, ST_DEGEN, 0, 0);
		add_vector(make_tq(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 2 * ONE, 0, 0), 0, ST_HIT, 0, 0);
		add_vector(make_tq(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, ONE, 0), 0, ST_HIT, 0, 0);
		add_vector(make_tq(0, 0, 0, ONE, 0, 0, 0, ONE, 0, -ONE, -ONE, 0), 0, ST_HIT, 0, 0);
		add_vector(make_tq(0, 0, 0, 3 * ONE, 0, 0, 0, 3 * ONE, 0, ONE, ONE, 40),
			0, ST_HIT, 0, 0);
		add_vector(make_tq(0, 0, 0, 3 * ONE, 0, 0, 0, 3 * ONE, 0, ONE, ONE, 70),
			0, ST_HIT, 0, 0);
		add_vector(make_tq(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMAX,
			CMAX, CMAX, CMAX), 0, ST_HIT, 0, 0);
		add_vector(make_tq(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, CMIN,
			CMIN, CMIN, CMIN), 0, ST_HIT, 0, 0);
		add_vector(make_tq(CMIN, CMAX, 0, CMAX, CMIN, 0, CMIN, CMIN, CMAX,
			0, 0, 0), 0, ST_HIT, 0, 0);
		add_vector(make_tq(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN,
			CMIN, CMAX, CMIN), 0, ST_HIT, 0, 0);
		add_vector(make_tq(-1, -1, -1, ONE - 1, -1, -1, -1, ONE - 1, -1,
			-1, -1, -1), 1, ST_HIT, 0, 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (vectors[i]) send(vectors[i].tq, vectors[i].known, vectors[i].want);
		run_random(100);

		write_reg(REG_TOLERANCE, '0);
		run_random(70);

		write_reg(REG_TOLERANCE, CFG_DATA_W'(32'h7fff_ffff));
		write_reg(REG_LIMIT, {CFG_DATA_W{1'b1}});
		run_random(70);

		write_reg(REG_TOLERANCE, CFG_DATA_W'(ONE));
		write_reg(REG_LIMIT, CFG_DATA_W'(64'd1) << 40);
		steady = 1'b1;
		run_random(100);
		steady = 1'b0;

		// writes to unmapped indexes leave both registers alone
		write_reg(IDX_SPARE_LO, {CFG_DATA_W{1'b1}});
		write_reg(IDX_SPARE_HI, '0);
		run_random(70);

		for (int p = 0; p < 4; p++) begin
			write_reg(REG_TOLERANCE, CFG_DATA_W'($urandom_range(0, 4000)));
			write_reg(REG_LIMIT, CFG_DATA_W'({$urandom, $urandom} >> $urandom_range(1, 63)));
			run_random(50);
		end
		write_reg(REG_TOLERANCE, CFG_DATA_W'(TOL_RESET));
		write_reg(REG_LIMIT, CFG_DATA_W'(LIMIT_RESET));
		run_random(20);

		item_ch.valid <= 1'b0;
		while (pending_proj.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
